>>> design/gcsa_pkg.sv
// ----------------------------------------------------------------------------
// gcsa_pkg
// Shared types and constants of the generation-checked slot allocator.
// ----------------------------------------------------------------------------
package gcsa_pkg;

  localparam int unsigned MaxSlotsDefault = 1024;
  localparam int unsigned CodeBitsDefault = 32;

  localparam int unsigned CfgW  = 11;
  localparam int unsigned SlotW = 10;
  localparam int unsigned CodeW = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_type_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SlotW-1:0] slot_index;
    logic [CodeW-1:0] handle_code;
  } in_t;

  typedef struct packed {
    logic             status;
    logic [SlotW-1:0] slot_out;
    logic [CodeW-1:0] code_out;
  } out_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic accept;
    logic commit;
    logic cfg_write;
  } cmd_t;

endpackage

>>> design/gcsa_ctrl.sv
// ----------------------------------------------------------------------------
// gcsa_ctrl
// Controller: sequences each request through a read cycle and a commit
// cycle and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module gcsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  output gcsa_pkg::cmd_t    cmd_o
);

  gcsa_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gcsa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = gcsa_pkg::ST_EXEC;
        end
      end
      gcsa_pkg::ST_EXEC: begin
        if (out_free) begin
          state_d = gcsa_pkg::ST_IDLE;
        end
      end
      default: state_d = gcsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = (state_q != gcsa_pkg::ST_IDLE);
    cfg_ready_o      = (state_q == gcsa_pkg::ST_IDLE) && !in_valid_i;
    cmd_o.accept     = (state_q == gcsa_pkg::ST_IDLE) && in_valid_i;
    cmd_o.commit     = (state_q == gcsa_pkg::ST_EXEC) && out_free;
    cmd_o.cfg_write  = cfg_valid_i && (state_q == gcsa_pkg::ST_IDLE) && !in_valid_i;
    out_valid_d      = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcsa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/gcsa_datapath.sv
// ----------------------------------------------------------------------------
// gcsa_datapath
// Datapath: link and code memories, free-list head, fill count, sequence
// generator, request register and result register.
// ----------------------------------------------------------------------------
module gcsa_datapath #(
  parameter int unsigned MAX_SLOTS = gcsa_pkg::MaxSlotsDefault,
  parameter int unsigned CODE_BITS = gcsa_pkg::CodeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gcsa_pkg::cmd_t                cmd_i,
  input  gcsa_pkg::in_t                 in_data_i,
  input  logic [gcsa_pkg::CfgW-1:0]     cfg_data_i,
  output gcsa_pkg::out_t                out_data_o
);

  localparam int unsigned IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CmpW = (CntW > gcsa_pkg::CfgW) ? CntW : gcsa_pkg::CfgW;
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(MAX_SLOTS);

  logic [CntW-1:0]      link_mem [MAX_SLOTS];
  logic [CODE_BITS-1:0] code_mem [MAX_SLOTS];

  logic [CntW-1:0]      cnt_q, head_q, head_d, fresh_q, fresh_d;
  logic                 empty_q, empty_d;
  logic [CODE_BITS-1:0] seq_q, seq_d;
  gcsa_pkg::in_t        req_q;
  logic [IdxW-1:0]      addr_q, rd_addr;
  logic [CntW-1:0]      link_rd_q;
  logic [CODE_BITS-1:0] code_rd_q;
  gcsa_pkg::out_t       out_q, out_d;

  logic                 entry_valid, in_range, handle_ok, alloc_ok;
  logic [CntW-1:0]      link_val;
  logic [CODE_BITS-1:0] code_val, seq_inc, seq_nx;
  logic                 code_we, link_we;
  logic [CODE_BITS-1:0] code_wd;
  logic [CntW-1:0]      link_wd;
  logic [CmpW-1:0]      cfg_ext, cfg_clamped;

  always_comb begin
    if (in_data_i.req_type == gcsa_pkg::REQ_ALLOC) begin
      rd_addr = head_q[IdxW-1:0];
    end else begin
      rd_addr = IdxW'(in_data_i.slot_index);
    end
  end

  assign entry_valid = CmpW'(addr_q) < CmpW'(fresh_q);
  assign code_val    = entry_valid ? code_rd_q : '0;
  assign link_val    = entry_valid ? link_rd_q : (CntW'(addr_q) + CntW'(1));
  assign in_range    = CmpW'(req_q.slot_index) < CmpW'(cnt_q);
  assign handle_ok   = in_range && (req_q.handle_code != '0)
                    && (req_q.handle_code == gcsa_pkg::CodeW'(code_val));
  assign alloc_ok    = !empty_q && (head_q < cnt_q);
  assign seq_inc     = seq_q + CODE_BITS'(1);
  assign seq_nx      = (seq_inc == '0) ? CODE_BITS'(1) : seq_inc;

  always_comb begin
    head_d   = head_q;
    empty_d  = empty_q;
    fresh_d  = fresh_q;
    seq_d    = seq_q;
    code_we  = 1'b0;
    link_we  = 1'b0;
    code_wd  = seq_nx;
    link_wd  = empty_q ? cnt_q : head_q;
    out_d    = '{status: gcsa_pkg::STATUS_ERR, slot_out: '0, code_out: '0};
    unique case (req_q.req_type)
      gcsa_pkg::REQ_ALLOC: begin
        if (alloc_ok) begin
          code_we        = 1'b1;
          code_wd        = seq_nx;
          seq_d          = seq_nx;
          out_d.status   = gcsa_pkg::STATUS_OK;
          out_d.slot_out = gcsa_pkg::SlotW'(head_q);
          out_d.code_out = gcsa_pkg::CodeW'(seq_nx);
          if (link_val >= cnt_q) begin
            empty_d = 1'b1;
            head_d  = '0;
          end else begin
            head_d  = link_val;
          end
          if (!entry_valid) begin
            fresh_d = CntW'(addr_q) + CntW'(1);
          end
        end
      end
      gcsa_pkg::REQ_FREE: begin
        if (handle_ok) begin
          code_we      = 1'b1;
          code_wd      = '0;
          link_we      = 1'b1;
          head_d       = CntW'(addr_q);
          empty_d      = 1'b0;
          seq_d        = seq_nx;
          out_d.status = gcsa_pkg::STATUS_OK;
        end
      end
      gcsa_pkg::REQ_LOOKUP: begin
        if (handle_ok) begin
          out_d.status   = gcsa_pkg::STATUS_OK;
          out_d.slot_out = req_q.slot_index;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cfg_ext = CmpW'(cfg_data_i);
    if (cfg_ext == '0) begin
      cfg_clamped = CmpW'(1);
    end else if (cfg_ext > MaxCmp) begin
      cfg_clamped = MaxCmp;
    end else begin
      cfg_clamped = cfg_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && code_we) begin
      code_mem[addr_q] <= code_wd;
    end
    if (cmd_i.commit && link_we) begin
      link_mem[addr_q] <= link_wd;
    end
    if (cmd_i.accept) begin
      code_rd_q <= code_mem[rd_addr];
      link_rd_q <= link_mem[rd_addr];
      req_q     <= in_data_i;
      addr_q    <= rd_addr;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= CntW'(MAX_SLOTS);
      head_q  <= '0;
      empty_q <= 1'b0;
      fresh_q <= '0;
      seq_q   <= CODE_BITS'(1);
    end else if (cmd_i.cfg_write) begin
      cnt_q   <= CntW'(cfg_clamped);
      head_q  <= '0;
      empty_q <= 1'b0;
      fresh_q <= '0;
    end else if (cmd_i.commit) begin
      head_q  <= head_d;
      empty_q <= empty_d;
      fresh_q <= fresh_d;
      seq_q   <= seq_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> design/generation_checked_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// generation_checked_slot_allocator_unit
// Pool allocator with a linked free list and per-slot generation codes.
// ----------------------------------------------------------------------------
// A request transaction (allocate, free or lookup) enters on the in channel
// and produces exactly one result transaction on the out channel. Each
// request first reads the link and code memories at the head slot or the
// handle index, then is checked, updates the free list and loads the result
// register in its commit cycle, which waits while the result register is
// full and stalled. No new request is accepted until the current one has
// committed. out_valid_o is registered and rises in the cycle after commit.
// While the receiver stalls, the result register holds and one more request
// can be accepted; it then waits in its commit cycle until the register frees.
// The slot_count register is written on the cfg channel while the block is
// idle and no request is offered; a single write rebuilds the free list,
// since a fill count marks all slots above it as untouched. Reset sets
// slot_count to MAX_SLOTS, the sequence number to one and the free list to all
// slots in order; no clearing pass is needed and requests are taken right
// after reset.
// ----------------------------------------------------------------------------
module generation_checked_slot_allocator_unit #(
  parameter int unsigned MAX_SLOTS = gcsa_pkg::MaxSlotsDefault,
  parameter int unsigned CODE_BITS = gcsa_pkg::CodeBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  gcsa_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output gcsa_pkg::out_t            out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gcsa_pkg::CfgW-1:0] cfg_data_i
);

  gcsa_pkg::cmd_t cmd;

  gcsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  gcsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .CODE_BITS (CODE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  a_commit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(out_valid_o && out_stall_i))
    else $error("Result committed while the result register is stalled.");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !cfg_ready_o))
    else $error("Block not busy after accepting a transaction.");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("Result valid not raised after commit.");
`endif

endmodule
